@@ rtl/soft_clip_waveshaper_top_macros.svh @@
// Assertion macros shared by the soft clip waveshaper RTL.
`ifndef SOFT_CLIP_WAVESHAPER_TOP_MACROS_SVH
`define SOFT_CLIP_WAVESHAPER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/scw_pkg.sv @@
// Shared constants of the soft clip waveshaper: register map and config widths.
package scw_pkg;

	localparam int IDX_W   = 2;
	localparam int CFG_W   = 17;
	localparam int CURVE_W = 16;

	localparam logic [IDX_W-1:0] REG_DRIVE = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIX   = 2'd1;
	localparam logic [IDX_W-1:0] REG_CURVE = 2'd2;

	localparam logic [CFG_W-1:0]   UNIT16      = 17'd65536;
	localparam logic [CFG_W-1:0]   DRIVE_RST   = 17'd0;
	localparam logic [CFG_W-1:0]   MIX_RST     = 17'd65536;
	localparam logic [CURVE_W-1:0] CURVE_RST   = 16'd4096;
	localparam int                 CURVE_FRAC  = 12;
	localparam int                 UNIT_SHIFT  = 16;

endpackage

@@ rtl/scw_pipe_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module scw_pipe_div #(
	parameter int NW = 8,
	parameter int DW = 4,
	parameter int QW = 4,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] out_side
);

	// The caller guarantees num >> QW is below den, so QW steps give the full quotient.
	logic          v_sk    [QW];
	logic [DW-1:0] rem_sk  [QW];
	logic [QW-1:0] low_sk  [QW];
	logic [QW-1:0] quo_sk  [QW];
	logic [DW-1:0] den_sk  [QW];
	logic [PW-1:0] side_sk [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic          v_i;
		logic [DW-1:0] rem_i;
		logic [QW-1:0] low_i;
		logic [QW-1:0] quo_i;
		logic [DW-1:0] den_i;
		logic [PW-1:0] side_i;
		logic [DW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = DW'(num >> QW);
			assign low_i  = num[QW-1:0];
			assign quo_i  = '0;
			assign den_i  = den;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_sk[k-1];
			assign rem_i  = rem_sk[k-1];
			assign low_i  = low_sk[k-1];
			assign quo_i  = quo_sk[k-1];
			assign den_i  = den_sk[k-1];
			assign side_i = side_sk[k-1];
		end

		assign trial = {rem_i, low_i[QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else begin
				v_sk[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_sk[k]  <= take ? DW'(trial - {1'b0, den_i}) : DW'(trial);
			low_sk[k]  <= low_i << 1;
			quo_sk[k]  <= {quo_i[QW-2:0], take};
			den_sk[k]  <= den_i;
			side_sk[k] <= side_i;
		end
	end

	assign out_valid = v_sk[QW-1];
	assign quo       = quo_sk[QW-1];
	assign out_side  = side_sk[QW-1];

endmodule

@@ rtl/soft_clip_waveshaper_top.sv @@
// Soft clip waveshaper with dry/wet mix: a fully pipelined top level.
//
//   channel   direction  handshake                 word
//   ------    ---------  ------------------------  -------------------------
//   input     in         start high, busy low      sample_in (Q2.F signed)
//   result    out        done strobe, one cycle    sample_out (Q2.F signed)
//   config    in         wr_en                     wr_index, wr_data
//
// Every word passes through the two bit-per-stage dividers and the registered
// stages around them on its way from acceptance to its done strobe.
// A new word may be accepted on every cycle, so busy is never raised.
// Reset clears the valid bits of all stages and loads the register defaults.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "soft_clip_waveshaper_top_macros.svh"

module soft_clip_waveshaper_top import scw_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_index,
	input  logic [CFG_W-1:0]              wr_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = SB - 3;
	localparam int QW  = SB + 3;
	localparam int D2W = QW + 5;
	localparam int LAT = 2 * QW + 10;

	// Constants rounded to nearest in Q.F.
	localparam longint unsigned T09_L = ((64'd9 << F) + 64'd5) / 64'd10;
	localparam longint unsigned T06_L = ((64'd6 << F) + 64'd5) / 64'd10;
	localparam longint unsigned C6_L  = ((64'd166667 << F) + 64'd500000) / 64'd1000000;

	localparam logic [F-1:0] T09   = F'(T09_L);
	localparam logic [F-1:0] T06   = F'(T06_L);
	localparam logic [F-1:0] C6    = F'(C6_L);
	localparam logic [F-1:0] HALF  = {1'b1, {(F-1){1'b0}}};
	localparam logic [F:0]   Q_ONE = {1'b1, {F{1'b0}}};

	localparam logic signed [SB+5:0] YMAX = (SB+6)'((64'sd1 <<< (SB-1)) - 64'sd1);
	localparam logic signed [SB+5:0] YMIN = -YMAX - (SB+6)'(1);

	typedef struct packed {
		logic signed [SB-1:0] x;
		logic                 neg;
		logic                 below;
		logic [F-1:0]         t;
		logic [F-1:0]         onemt;
	} side_t;

	typedef struct packed {
		side_t    base;
		logic [F:0] s;
	} side2_t;

	// Configuration registers; the user must write them only while the pipeline is empty,
	// which the block does not enforce; later stages read them directly.
	logic [CFG_W-1:0]   drive_q;
	logic [CFG_W-1:0]   mix_q;
	logic [CURVE_W-1:0] curve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= DRIVE_RST;
			mix_q   <= MIX_RST;
			curve_q <= CURVE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DRIVE: drive_q <= wr_data;
				REG_MIX:   mix_q   <= wr_data;
				REG_CURVE: curve_q <= wr_data[CURVE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CFG_W-1:0] drive_sat;
	logic [CFG_W-1:0] mix_sat;
	assign drive_sat = (drive_q > UNIT16) ? UNIT16 : drive_q;
	assign mix_sat   = (mix_q > UNIT16) ? UNIT16 : mix_q;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: threshold from drive, magnitude and sign of the sample.
	logic [F+16:0] t_prod;
	logic [SB-1:0] a_in;
	assign t_prod = (F+17)'(T06) * (F+17)'(drive_sat);
	assign a_in   = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);

	logic                 v_s1;
	logic signed [SB-1:0] x_s1;
	logic                 neg_s1;
	logic [SB-1:0]        a_s1;
	logic [F-1:0]         t_s1;

	// Stage 2: choose the branch and set up the first division.
	logic         below_c;
	logic [F-1:0] onemt_c;
	logic [SB-1:0] over_c;
	assign below_c = a_s1 < SB'(t_s1);
	assign onemt_c = F'(Q_ONE - (F+1)'(t_s1));
	assign over_c  = a_s1 - SB'(t_s1);

	logic            v_s2;
	logic [SB+F-1:0] num1_s2;
	logic [F-1:0]    den1_s2;
	side_t           side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= sample_in;
		neg_s1 <= sample_in[SB-1];
		a_s1   <= a_in;
		t_s1   <= T09 - F'(t_prod >> UNIT_SHIFT);

		num1_s2       <= {(below_c ? a_s1 : over_c), {F{1'b0}}};
		den1_s2       <= below_c ? t_s1 : onemt_c;
		side_s2.x     <= x_s1;
		side_s2.neg   <= neg_s1;
		side_s2.below <= below_c;
		side_s2.t     <= t_s1;
		side_s2.onemt <= onemt_c;
	end

	// First division: u = a/T below the threshold, o = (a-T)/(1-T) at or above it.
	logic          d1_v;
	logic [QW-1:0] d1_q;
	side_t         d1_side;

	scw_pipe_div #(
		.NW(SB + F),
		.DW(F),
		.QW(QW),
		.PW($bits(side_t))
	) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.num      (num1_s2),
		.den      (den1_s2),
		.in_side  (side_s2),
		.out_valid(d1_v),
		.quo      (d1_q),
		.out_side (d1_side)
	);

	// Stage 3: u squared and the knee denominator 1 + o*curve.
	logic [F-1:0]      u_c;
	logic [2*F-1:0]    usq_c;
	logic [QW+15:0]    oc_c;
	assign u_c   = F'(d1_q);
	assign usq_c = (2*F)'(u_c) * (2*F)'(u_c);
	assign oc_c  = (QW+16)'(d1_q) * (QW+16)'(curve_q);

	logic           v_s3, v_s4, v_s5, v_s6;
	logic [QW-1:0]  q1_s3, q1_s4, q1_s5, q1_s6;
	logic [D2W-1:0] den2_s3, den2_s4, den2_s5, den2_s6;
	side_t          side_s3, side_s4, side_s5, side_s6;
	logic [F-1:0]   u2_s3, u2_s4;
	logic [F-1:0]   m_s4;
	logic [F:0]     poly_s5;
	logic [F:0]     s_s6;

	// Stage 4: m = 1/2 - u^2 * c6.
	logic [2*F-1:0] u2c_c;
	assign u2c_c = (2*F)'(u2_s3) * (2*F)'(C6);

	// Stage 5: poly = 1 - u^2 * m.
	logic [2*F-1:0] u2m_c;
	assign u2m_c = (2*F)'(u2_s4) * (2*F)'(m_s4);

	// Stage 6: s = u * poly.
	logic [2*F:0] up_c;
	assign up_c = (2*F+1)'(F'(q1_s5)) * (2*F+1)'(poly_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= d1_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		q1_s3   <= d1_q;
		u2_s3   <= F'(usq_c >> F);
		den2_s3 <= D2W'(Q_ONE) + D2W'(oc_c >> CURVE_FRAC);
		side_s3 <= d1_side;

		q1_s4   <= q1_s3;
		u2_s4   <= u2_s3;
		m_s4    <= HALF - F'(u2c_c >> F);
		den2_s4 <= den2_s3;
		side_s4 <= side_s3;

		q1_s5   <= q1_s4;
		poly_s5 <= Q_ONE - (F+1)'(u2m_c >> F);
		den2_s5 <= den2_s4;
		side_s5 <= side_s4;

		q1_s6   <= q1_s5;
		s_s6    <= (F+1)'(up_c >> F);
		den2_s6 <= den2_s5;
		side_s6 <= side_s5;
	end

	// Second division: c = o / (1 + o*curve). Below the threshold its quotient
	// is discarded and only the carried polynomial value is used.
	side2_t          side2_in;
	logic            d2_v;
	logic [QW-1:0]   d2_q;
	side2_t          d2_side;

	assign side2_in.base = side_s6;
	assign side2_in.s    = s_s6;

	scw_pipe_div #(
		.NW(QW + F),
		.DW(D2W),
		.QW(QW),
		.PW($bits(side2_t))
	) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.num      ({q1_s6, {F{1'b0}}}),
		.den      (den2_s6),
		.in_side  (side2_in),
		.out_valid(d2_v),
		.quo      (d2_q),
		.out_side (d2_side)
	);

	// Stage 7: shaped magnitude, s*T below the threshold, T + c*(1-T) at or above it.
	logic [QW-1:0]   op_a;
	logic [F-1:0]    op_b;
	logic [QW+F-1:0] sh_prod;
	logic [QW-1:0]   sh_c;
	logic [QW:0]     mag_c;
	assign op_a    = d2_side.base.below ? QW'(d2_side.s) : d2_q;
	assign op_b    = d2_side.base.below ? d2_side.base.t : d2_side.base.onemt;
	assign sh_prod = (QW+F)'(op_a) * (QW+F)'(op_b);
	assign sh_c    = QW'(sh_prod >> F);
	assign mag_c   = d2_side.base.below ? (QW+1)'(sh_c)
	                                    : (QW+1)'(sh_c) + (QW+1)'(d2_side.base.t);

	logic                 v_s7, v_s8, v_s9, done_q;
	logic [SB:0]          mag_s7;
	logic                 neg_s7;
	logic                 below_s7;
	logic signed [SB-1:0] x_s7, x_s8, x_s9;
	logic signed [SB+2:0] diff_s8;
	logic signed [SB+4:0] qd_s9;
	logic signed [SB-1:0] out_q;

	// Stage 8: restore the sign and form wet - dry.
	logic signed [SB+1:0] magx_c;
	logic signed [SB+1:0] wet_c;
	assign magx_c = $signed({1'b0, mag_s7});
	assign wet_c  = neg_s7 ? -magx_c : magx_c;

	// Stage 9: (wet - dry) * mix / 65536, truncated toward zero.
	logic signed [SB+20:0] p_c;
	logic signed [SB+20:0] bias_c;
	assign p_c    = (SB+21)'(diff_s8) * (SB+21)'($signed({1'b0, mix_sat}));
	assign bias_c = p_c[SB+20] ? $signed((SB+21)'(17'd65535)) : '0;

	// Stage 10: add the dry sample back and saturate.
	logic signed [SB+5:0] y_c;
	assign y_c = (SB+6)'(x_s9) + (SB+6)'(qd_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s7   <= d2_v;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			done_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		mag_s7   <= (SB+1)'(mag_c);
		neg_s7   <= d2_side.base.neg;
		below_s7 <= d2_side.base.below;
		x_s7     <= d2_side.base.x;

		diff_s8 <= (SB+3)'(wet_c) - (SB+3)'(x_s7);
		x_s8    <= x_s7;

		qd_s9 <= (SB+5)'((p_c + bias_c) >>> UNIT_SHIFT);
		x_s9  <= x_s8;

		if (y_c > YMAX) begin
			out_q <= SB'(YMAX);
		end else if (y_c < YMIN) begin
			out_q <= SB'(YMIN);
		end else begin
			out_q <= SB'(y_c);
		end
	end

	assign done       = done_q;
	assign sample_out = out_q;

	// A result strobe always traces back to a word accepted a fixed latency earlier.
	`SCW_ASSERT_NOW(a_done_src, done, $past(accept, LAT), "result without a source word")

	// The knee denominator never drops below one.
	`SCW_ASSERT_NOW(a_den2_min, v_s3, den2_s3 >= D2W'(Q_ONE), "knee denominator below one")

	// Below the threshold the shaped magnitude stays under one.
	`SCW_ASSERT_NOW(a_below_mag, v_s7 && below_s7, mag_s7 < (SB+1)'(Q_ONE),
		"shaped magnitude out of range")

	// A valid word in stage seven moves on to stage eight.
	`SCW_ASSERT_NEXT(a_s7_flow, v_s7, v_s8, "pipeline dropped a word")

endmodule

@@ tb/soft_clip_waveshaper_top_tb.sv @@
// Self-checking testbench for the soft clip waveshaper top level.
`timescale 1ns / 100ps

module soft_clip_waveshaper_top_tb;
	import scw_pkg::*;

	localparam int SB        = 24;
	localparam int FB        = SB - 3;
	// Acceptance-to-strobe latency of the block; the drain wait adds a margin.
	localparam int LATENCY   = 2 * (SB + 3) + 10;
	localparam int DRAIN     = LATENCY + 16;
	localparam int WATCHDOG  = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [SB-1:0] sample_in;
	logic                 done;
	logic signed [SB-1:0] sample_out;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_index;
	logic [CFG_W-1:0]     wr_data;

	soft_clip_waveshaper_top #(.SAMPLE_BITS(SB)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample_in  (sample_in),
		.done       (done),
		.sample_out (sample_out),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Local copy of the configuration registers, updated on every write.
	logic [CFG_W-1:0]   cur_drive;
	logic [CFG_W-1:0]   cur_mix;
	logic [CURVE_W-1:0] cur_curve;

	logic signed [SB-1:0] pending_words[$];
	logic signed [SB-1:0] shaped_words[$];

	int unsigned errors;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned idle_cycles;
	int unsigned phases;

	// Threshold T in unsigned Q.F for a given drive, drive clamped at one.
	function automatic longint unsigned clip_threshold(logic [CFG_W-1:0] drv);
		longint unsigned d;
		longint unsigned t09;
		longint unsigned t06;
		d   = (drv > UNIT16) ? 64'(UNIT16) : 64'(drv);
		t09 = ((64'd9 << FB) + 64'd5) / 64'd10;
		t06 = ((64'd6 << FB) + 64'd5) / 64'd10;
		return t09 - ((t06 * d) >> UNIT_SHIFT);
	endfunction

	// Shaped and mixed output for one sample under the current settings.
	function automatic logic signed [SB-1:0] shape_sample(logic signed [SB-1:0] x_in);
		longint unsigned one_q;
		longint unsigned t;
		longint unsigned onemt;
		longint unsigned a;
		longint unsigned mag;
		longint unsigned c6;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned m;
		longint unsigned q;
		longint unsigned s;
		longint unsigned on;
		longint unsigned den;
		longint unsigned cl;
		longint          x;
		longint          wet;
		longint          mx;
		longint          y;
		longint          hi;
		longint          lo;
		one_q = 64'd1 << FB;
		t     = clip_threshold(cur_drive);
		onemt = one_q - t;
		mx    = (cur_mix > UNIT16) ? longint'(UNIT16) : longint'(cur_mix);
		x     = longint'(x_in);
		a     = (x < 0) ? longint'(-x) : x;
		if (a < t) begin
			// Below the threshold: odd polynomial on the normalized sample.
			c6   = ((64'd166667 << FB) + 64'd500000) / 64'd1000000;
			u    = (a << FB) / t;
			u2   = (u * u) >> FB;
			m    = (one_q >> 1) - ((u2 * c6) >> FB);
			q    = (u2 * m) >> FB;
			s    = (u * (one_q - q)) >> FB;
			mag  = (s * t) >> FB;
		end else begin
			// At or above it: the normalized overshoot is compressed.
			on   = ((a - t) << FB) / onemt;
			den  = one_q + ((on * 64'(cur_curve)) >> CURVE_FRAC);
			cl   = (on << FB) / den;
			mag  = t + ((cl * onemt) >> FB);
		end
		wet = (x < 0) ? -longint'(mag) : longint'(mag);
		y   = x + ((wet - x) * mx) / longint'(UNIT16);
		hi  = (longint'(1) << (SB - 1)) - 1;
		lo  = -hi - 1;
		if (y > hi) y = hi;
		if (y < lo) y = lo;
		return y[SB-1:0];
	endfunction

	// Driver: bursts of random length with random gaps in between.
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			sample_in  <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			// A word is taken at this edge if start was high and busy low.
			if (start && !busy) begin
				shaped_words.push_back(shape_sample(sample_in));
				words_in++;
			end
			if (start && busy) begin
				// Hold the word until the block takes it.
			end else if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_words.size() != 0) begin
				start     <= 1'b1;
				sample_in <= pending_words.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(40, 1);
					// A third of the bursts run back to back with no gap.
					gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe must match the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			words_out++;
			if (shaped_words.size() == 0) begin
				$error("sample_out: unexpected word, actual %0d", sample_out);
				errors++;
			end else begin
				logic signed [SB-1:0] want;
				want = shaped_words.pop_front();
				if (sample_out !== want) begin
					$error("sample_out: expected %0d, actual %0d", want, sample_out);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("timeout with %0d words outstanding", shaped_words.size());
				$display("soft_clip_waveshaper_top_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_DRIVE: cur_drive = val;
			REG_MIX:   cur_mix   = val;
			default:   cur_curve = val[CURVE_W-1:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Block until every queued word is accepted and every result has come.
	task automatic drain_all();
		while (pending_words.size() != 0 || start || shaped_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Random words: full-range values, values near the knee, and small ones.
	task automatic queue_random(int unsigned n);
		longint          t;
		longint          v;
		int unsigned     pick;
		for (int unsigned i = 0; i < n; i++) begin
			t    = longint'(clip_threshold(cur_drive));
			pick = $urandom_range(9, 0);
			if (pick < 5) begin
				v = longint'($signed(SB'($urandom)));
			end else if (pick < 8) begin
				v = t + longint'($urandom_range(65536, 0)) - 32768;
				if ($urandom_range(1, 0)) v = -v;
			end else begin
				v = longint'($urandom_range(4095, 0)) - 2048;
			end
			pending_words.push_back(v[SB-1:0]);
		end
	endtask

	task automatic run_phase(logic [CFG_W-1:0] drv, logic [CFG_W-1:0] mix,
				 logic [CFG_W-1:0] crv, int unsigned n);
		drain_all();
		write_reg(REG_DRIVE, drv);
		write_reg(REG_MIX, mix);
		write_reg(REG_CURVE, crv);
		queue_random(n);
		phases++;
	endtask

	initial begin
		longint t;
		errors    = 0;
		words_in  = 0;
		words_out = 0;
		phases    = 0;
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		cur_drive = DRIVE_RST;
		cur_mix   = MIX_RST;
		cur_curve = CURVE_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset settings: range ends, zero, unity and
		// both sides of the threshold, where the curve has its jump.
		t = longint'(clip_threshold(cur_drive));
		pending_words.push_back(24'sd0);
		pending_words.push_back(24'sd1);
		pending_words.push_back(-24'sd1);
		pending_words.push_back(24'sh7FFFFF);
		pending_words.push_back(24'sh800000);
		pending_words.push_back(24'sh800001);
		pending_words.push_back(24'sd2097152);
		pending_words.push_back(-24'sd2097152);
		for (longint d = -1; d <= 1; d++) begin
			pending_words.push_back(SB'(t + d));
			pending_words.push_back(SB'(-(t + d)));
		end
		queue_random(256);

		// Settings sweep; the extremes include drive and mix above one and
		// a curve below one, zero among them.
		run_phase(17'd65536, 17'd65536, 17'd40960, 150);
		run_phase(17'd131071, 17'd0, 17'd4096, 140);
		run_phase(17'd32768, 17'd32768, 17'd0, 150);
		run_phase(17'd0, 17'd131071, 17'd65535, 150);
		run_phase(17'd90000, 17'd12345, 17'd1000, 140);
		run_phase(17'd16384, 17'd65535, 17'd20480, 150);
		run_phase(17'($urandom_range(65536, 0)), 17'($urandom_range(65536, 0)),
			  17'($urandom_range(40960, 4096)), 150);
		drain_all();

		$display("covered %0d words in, %0d words out over %0d settings",
			 words_in, words_out, phases + 1);
		if (errors == 0) begin
			$display("soft_clip_waveshaper_top_tb OK");
		end else begin
			$display("soft_clip_waveshaper_top_tb NOT OK");
		end
		$finish;
	end

endmodule
